/* design/packbits_rle_decoder_assert.svh */
// Assertion macros for the PackBits decoder.
// Used by the top level; needs no other file.
`ifndef PACKBITS_RLE_DECODER_ASSERT_SVH
`define PACKBITS_RLE_DECODER_ASSERT_SVH

// Same-cycle implication, checked at each rising edge outside reset
`define PBD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pbd assertion failed");

// Next-cycle implication
`define PBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pbd assertion failed");

`endif

/* design/pbd_pkg.sv */
// Shared constants, types and helpers of the PackBits decoder.
// No dependencies; compiled first.
`default_nettype none

package pbd_pkg;

	// Configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_OUTPUT_LIMIT = 1'b0;   // word index of output_limit

	// Field widths
	localparam int LIMIT_W  = 21;
	localparam int RUN_W    = 8;
	localparam int OUT_LANES = 8;
	localparam int OUT_W    = 8 * OUT_LANES;
	localparam int CNT_W    = 4;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 21'd1048576;

	// Parameter defaults
	localparam int DEF_MAX_OUTPUT = 1048576;
	localparam int DEF_LANE_BYTES = 8;

	// Header byte that is skipped (-128)
	localparam logic [7:0] HDR_SKIP = 8'h80;

	// Decode modes
	localparam logic [1:0] MODE_HEADER  = 2'd0;
	localparam logic [1:0] MODE_LITERAL = 2'd1;
	localparam logic [1:0] MODE_REPEAT  = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic take;   // input request accepted this cycle
		logic step;   // emit one chunk of the pending repeat run
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic rep_start;   // an accepted byte now would start a repeat run
		logic last_chunk;  // the pending run fits into one chunk
		logic out_valid;   // output register holds a result
	} sts_t;

	// Lane width clamped to 1..8
	function automatic int lane_clamp(input int n);
		int r;
		r = n;
		if (r < 1) r = 1;
		if (r > OUT_LANES) r = OUT_LANES;
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/pbd_in_if.sv */
// Input channel of the PackBits decoder: valid/ready plus one compressed byte.
// No dependencies.
`default_nettype none

interface pbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       frame_last;

	modport source (output valid, output in_byte, output frame_last, input ready);
	modport sink   (input valid, input in_byte, input frame_last, output ready);
endinterface

`default_nettype wire

/* design/pbd_out_if.sv */
// Output channel of the PackBits decoder: valid/ready plus one result.
// No dependencies.
`default_nettype none

interface pbd_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_bytes;
	logic [3:0]  byte_count;
	logic        run_last;
	logic        limit_hit;

	modport source (output valid, output out_bytes, output byte_count,
		output run_last, output limit_hit, input ready);
	modport sink   (input valid, input out_bytes, input byte_count,
		input run_last, input limit_hit, output ready);
endinterface

`default_nettype wire

/* design/packbits_rle_decoder.sv */
// PackBits run-length decoder. Takes one compressed byte per request and
// returns decoded bytes: a literal byte leaves as a one-byte result in the
// cycle after it is taken, and a header byte gives no result. A repeat
// run's data byte (2..128 copies) leaves as ceil(n / LANE_BYTES) results
// through the output register, one per cycle while the output is not
// stalled; no new byte is taken while a run expands. A stalled output holds
// the decoder. Decoded bytes per frame stop at min(output_limit, MAX_OUTPUT);
// the byte marked frame_last ends the frame. output_limit sits at APB byte
// address 0; write it only while the decoder is idle.
// Depends on pbd_pkg, pbd_in_if, pbd_out_if, pbd_cfg, pbd_ctrl, pbd_dp.
`default_nettype none

`include "packbits_rle_decoder_assert.svh"

module packbits_rle_decoder #(
	parameter int MAX_OUTPUT = pbd_pkg::DEF_MAX_OUTPUT,
	parameter int LANE_BYTES = pbd_pkg::DEF_LANE_BYTES
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	pbd_in_if.sink                               in_ch,
	pbd_out_if.source                            out_ch,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [pbd_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [pbd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [pbd_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                 pready
);
	import pbd_pkg::*;

	localparam int LaneW = lane_clamp(LANE_BYTES);

	logic [LIMIT_W-1:0] eff_limit;
	cmd_t               cmd;
	sts_t               sts;

	pbd_cfg #(.MAX_OUTPUT(MAX_OUTPUT)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.eff_limit (eff_limit)
	);

	pbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_ready (out_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pbd_dp #(.LANE_W(LaneW)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_byte    (in_ch.in_byte),
		.frame_last (in_ch.frame_last),
		.limit      (eff_limit),
		.out_ready  (out_ch.ready),
		.out_valid  (out_ch.valid),
		.out_bytes  (out_ch.out_bytes),
		.byte_count (out_ch.byte_count),
		.run_last   (out_ch.run_last),
		.limit_hit  (out_ch.limit_hit)
	);

	// results carry 1..LaneW bytes
	`PBD_ASSERT_NOW(a_count_range, clk, arst_n, out_ch.valid, (out_ch.byte_count >= CNT_W'(1)) && (out_ch.byte_count <= CNT_W'(LaneW)))
	// only the final chunk of a run may be partial
	`PBD_ASSERT_NOW(a_partial_is_last, clk, arst_n, out_ch.valid && (out_ch.byte_count != CNT_W'(LaneW)), out_ch.run_last)
	// the limit cuts a run, so reaching it closes the run
	`PBD_ASSERT_NOW(a_limit_is_last, clk, arst_n, out_ch.valid && out_ch.limit_hit, out_ch.run_last)
	// taking a byte and expanding a run never overlap
	`PBD_ASSERT_NOW(a_take_xor_step, clk, arst_n, 1'b1, $onehot0({cmd.take, cmd.step}))

endmodule

`default_nettype wire

/* design/pbd_cfg.sv */
// APB register block of the PackBits decoder: holds output_limit and
// presents the limit clamped to MAX_OUTPUT. Depends on pbd_pkg.
`default_nettype none

module pbd_cfg #(
	parameter int MAX_OUTPUT = pbd_pkg::DEF_MAX_OUTPUT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [pbd_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [pbd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [pbd_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                 pready,
	output logic      [pbd_pkg::LIMIT_W-1:0]     eff_limit
);
	import pbd_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	logic               reg_sel;
	logic               wr_en;

	assign reg_sel = (paddr[APB_ADDR_W-1] == REG_OUTPUT_LIMIT);
	assign wr_en   = psel && penable && pwrite && reg_sel;
	assign pready  = 1'b1;

	// output_limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (wr_en) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = {{(APB_DATA_W-LIMIT_W){1'b0}}, limit_q};
		end
	end

	// limits above MAX_OUTPUT act as MAX_OUTPUT
	always_comb begin
		if ({{(32-LIMIT_W){1'b0}}, limit_q} > 32'(MAX_OUTPUT)) begin
			eff_limit = LIMIT_W'(MAX_OUTPUT);
		end else begin
			eff_limit = limit_q;
		end
	end

endmodule

`default_nettype wire

/* design/pbd_ctrl.sv */
// Controller of the PackBits decoder: accepts bytes and sequences the
// chunks of a repeat run. Depends on pbd_pkg.
`default_nettype none

module pbd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          out_ready,
	input  wire pbd_pkg::sts_t sts,
	output pbd_pkg::cmd_t      cmd
);
	import pbd_pkg::*;

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_EXPAND = 1'b1;

	logic state_q;
	logic slot_free;
	logic accept;

	// output register empty, or emptied this cycle
	assign slot_free = !sts.out_valid || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && slot_free;
	assign accept    = in_valid && in_ready;

	assign cmd.take = accept;
	assign cmd.step = (state_q == ST_EXPAND) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && sts.rep_start) state_q <= ST_EXPAND;
				end
				ST_EXPAND: begin
					if (slot_free && sts.last_chunk) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* design/pbd_dp.sv */
// Datapath of the PackBits decoder: frame state, run counter, byte count
// and the output register. Depends on pbd_pkg.
`default_nettype none

module pbd_dp #(
	parameter int LANE_W = pbd_pkg::DEF_LANE_BYTES
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pbd_pkg::cmd_t                 cmd,
	output pbd_pkg::sts_t                      sts,
	input  wire logic [7:0]                    in_byte,
	input  wire logic                          frame_last,
	input  wire logic [pbd_pkg::LIMIT_W-1:0]   limit,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output logic      [pbd_pkg::OUT_W-1:0]     out_bytes,
	output logic      [pbd_pkg::CNT_W-1:0]     byte_count,
	output logic                               run_last,
	output logic                               limit_hit
);
	import pbd_pkg::*;

	localparam logic [RUN_W-1:0] LaneRun = RUN_W'(LANE_W);
	localparam logic [CNT_W-1:0] LaneCnt = CNT_W'(LANE_W);

	// frame state
	logic [1:0]         mode_q;
	logic [RUN_W-1:0]   run_q;
	logic [LIMIT_W-1:0] bw_q;
	logic               done_q;
	// pending repeat run
	logic [7:0]         rep_byte_q;
	logic [RUN_W-1:0]   total_q;
	logic               last_q;
	// output register
	logic               out_valid_q;
	logic [OUT_W-1:0]   out_bytes_q;
	logic [CNT_W-1:0]   byte_count_q;
	logic               run_last_q;
	logic               limit_hit_q;

	logic               done_eff;
	logic               lit_emit;
	logic [LIMIT_W-1:0] room;
	logic [RUN_W-1:0]   run_total;
	logic [CNT_W-1:0]   chunk_cnt;
	logic [LIMIT_W-1:0] bw_lit;
	logic [LIMIT_W-1:0] bw_chunk;
	logic [RUN_W-1:0]   run_dec;
	logic [OUT_W-1:0]   chunk_word;

	// limit reached now, even if the limit moved between frames
	assign done_eff  = done_q || (bw_q >= limit);
	assign lit_emit  = (mode_q == MODE_LITERAL) && !done_eff;

	assign sts.rep_start  = (mode_q == MODE_REPEAT) && !done_eff;
	assign sts.last_chunk = (total_q <= LaneRun);
	assign sts.out_valid  = out_valid_q;

	// run length cut to the room left under the limit
	assign room = limit - bw_q;
	always_comb begin
		if ({{(LIMIT_W-RUN_W){1'b0}}, run_q} > room) begin
			run_total = room[RUN_W-1:0];
		end else begin
			run_total = run_q;
		end
	end

	assign bw_lit  = bw_q + LIMIT_W'(1);
	assign run_dec = run_q - RUN_W'(1);

	// next chunk of the repeat run
	assign chunk_cnt = sts.last_chunk ? total_q[CNT_W-1:0] : LaneCnt;
	assign bw_chunk  = bw_q + {{(LIMIT_W-CNT_W){1'b0}}, chunk_cnt};
	always_comb begin
		for (int i = 0; i < OUT_LANES; i++) begin
			chunk_word[8*i +: 8] = (CNT_W'(i) < chunk_cnt) ? rep_byte_q : 8'h00;
		end
	end

	// frame state and pending run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HEADER;
			run_q  <= '0;
			bw_q   <= '0;
			done_q <= 1'b0;
			last_q <= 1'b0;
		end else if (cmd.take && frame_last && !sts.rep_start) begin
			// frame end; a repeat run closes the frame after its last chunk
			mode_q <= MODE_HEADER;
			run_q  <= '0;
			bw_q   <= '0;
			done_q <= 1'b0;
		end else if (cmd.take) begin
			if (done_eff) begin
				done_q <= 1'b1;
			end else begin
				case (mode_q)
					MODE_HEADER: begin
						if (in_byte < HDR_SKIP) begin
							mode_q <= MODE_LITERAL;
							run_q  <= in_byte + RUN_W'(1);
						end else if (in_byte > HDR_SKIP) begin
							mode_q <= MODE_REPEAT;
							run_q  <= RUN_W'(9'd257 - {1'b0, in_byte});
						end
					end
					MODE_LITERAL: begin
						bw_q  <= bw_lit;
						run_q <= run_dec;
						if (bw_lit >= limit) done_q <= 1'b1;
						if (run_dec == '0) mode_q <= MODE_HEADER;
					end
					default: begin
						last_q <= frame_last;
					end
				endcase
			end
		end else if (cmd.step) begin
			if (sts.last_chunk && last_q) begin
				// run done and the frame ends with it
				mode_q <= MODE_HEADER;
				run_q  <= '0;
				bw_q   <= '0;
				done_q <= 1'b0;
			end else if (sts.last_chunk) begin
				bw_q   <= bw_chunk;
				mode_q <= MODE_HEADER;
				run_q  <= '0;
				done_q <= (bw_chunk >= limit);
			end else begin
				bw_q <= bw_chunk;
			end
		end
	end

	// repeat run payload
	always_ff @(posedge clk) begin
		if (cmd.take && sts.rep_start) begin
			rep_byte_q <= in_byte;
			total_q    <= run_total;
		end else if (cmd.step) begin
			total_q <= total_q - {{(RUN_W-CNT_W){1'b0}}, chunk_cnt};
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.take && lit_emit) || cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.take && lit_emit) begin
			out_bytes_q  <= {{(OUT_W-8){1'b0}}, in_byte};
			byte_count_q <= CNT_W'(1);
			run_last_q   <= 1'b1;
			limit_hit_q  <= (bw_lit >= limit);
		end else if (cmd.step) begin
			out_bytes_q  <= chunk_word;
			byte_count_q <= chunk_cnt;
			run_last_q   <= sts.last_chunk;
			limit_hit_q  <= (bw_chunk >= limit);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_bytes  = out_bytes_q;
	assign byte_count = byte_count_q;
	assign run_last   = run_last_q;
	assign limit_hit  = limit_hit_q;

endmodule

`default_nettype wire
